[rtl/dcf_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the command framer.
package dcf_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 252;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W = 16;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [BYTE_W-1:0] LEN_OFFSET = 8'd3;
	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST = 8'h5A;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hA5;

	// Register indexes on the configuration port.
	localparam logic REG_HEADER_FIRST = 1'b0;
	localparam logic REG_HEADER_SECOND = 1'b1;

	// Position of a result beat within the output sequence of one input beat.
	typedef enum logic [2:0] {
		R_HDR1 = 3'd0,
		R_HDR2 = 3'd1,
		R_LEN  = 3'd2,
		R_CMD  = 3'd3,
		R_DATA = 3'd4,
		R_CRCL = 3'd5,
		R_CRCH = 3'd6
	} res_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_end;
		logic              run_end;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
	} headers_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/dcf_regs.sv]
// APB-style register file holding the two frame header bytes.
module dcf_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dcf_pkg::ADDR_W-1:0]           paddr,
	input  logic [dcf_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [dcf_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	output dcf_pkg::headers_t                    headers
);

	logic                          wr_en;
	logic                          reg_sel;
	logic [dcf_pkg::BYTE_W-1:0]    header_first_q;
	logic [dcf_pkg::BYTE_W-1:0]    header_second_q;
	logic [dcf_pkg::BYTE_W-1:0]    rd_byte;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q <= dcf_pkg::HEADER_FIRST_RST;
			header_second_q <= dcf_pkg::HEADER_SECOND_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				dcf_pkg::REG_HEADER_FIRST: header_first_q <= pwdata[7:0];
				dcf_pkg::REG_HEADER_SECOND: header_second_q <= pwdata[7:0];
				default: header_first_q <= header_first_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			dcf_pkg::REG_HEADER_FIRST: rd_byte = header_first_q;
			dcf_pkg::REG_HEADER_SECOND: rd_byte = header_second_q;
			default: rd_byte = header_first_q;
		endcase
	end

	assign prdata = {24'h000000, rd_byte};
	assign headers.header_first = header_first_q;
	assign headers.header_second = header_second_q;

endmodule

[rtl/dcf_emit.sv]
// Input beat register, result sequencer and running frame/CRC state.
module dcf_emit #(
	parameter int unsigned MAX_PAYLOAD = dcf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dcf_pkg::BYTE_W-1:0]    command_code,
	input  logic [dcf_pkg::BYTE_W-1:0]    payload_count,
	input  logic [dcf_pkg::BYTE_W-1:0]    payload_byte,
	input  logic                          is_first,
	input  logic                          is_last,
	input  dcf_pkg::headers_t             headers,
	input  logic                          out_ready,
	output logic                          res_valid,
	output dcf_pkg::result_t              res
);

	localparam logic [dcf_pkg::BYTE_W-1:0] MaxCount = 8'(MAX_PAYLOAD);

	logic                          valid_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic [dcf_pkg::BYTE_W-1:0]    data_s1;
	logic [dcf_pkg::BYTE_W-1:0]    cmd_s1;
	logic [dcf_pkg::BYTE_W-1:0]    len_s1;
	logic [dcf_pkg::CRC_W-1:0]     crc_cmd_s1;
	dcf_pkg::res_idx_t             idx_q;
	logic                          frame_open_q;
	logic [dcf_pkg::CRC_W-1:0]     crc_q;

	logic                          drop;
	logic                          at_last;
	logic                          take;
	logic                          done;
	logic                          load;
	logic [dcf_pkg::BYTE_W-1:0]    count_clip;
	logic [dcf_pkg::CRC_W-1:0]     crc_base;
	logic [dcf_pkg::CRC_W-1:0]     crc_new;

	assign count_clip = (payload_count > MaxCount) ? MaxCount : payload_count;

	assign drop = valid_s1 && !first_s1 && !frame_open_q;
	assign res_valid = valid_s1 && !drop;
	assign at_last = (idx_q == (last_s1 ? dcf_pkg::R_CRCH : dcf_pkg::R_DATA));
	assign take = res_valid && out_ready;
	assign done = drop || (take && at_last);
	assign in_ready = !valid_s1 || done;
	assign load = in_valid && in_ready;

	assign crc_base = first_s1 ? crc_cmd_s1 : crc_q;
	assign crc_new = dcf_pkg::crc_feed(crc_base, data_s1);

	always_comb begin
		res.frame_end = 1'b0;
		res.run_end = at_last;
		case (idx_q)
			dcf_pkg::R_HDR1: res.frame_byte = headers.header_first;
			dcf_pkg::R_HDR2: res.frame_byte = headers.header_second;
			dcf_pkg::R_LEN:  res.frame_byte = len_s1;
			dcf_pkg::R_CMD:  res.frame_byte = cmd_s1;
			dcf_pkg::R_DATA: res.frame_byte = data_s1;
			dcf_pkg::R_CRCL: res.frame_byte = crc_new[7:0];
			dcf_pkg::R_CRCH: begin
				res.frame_byte = crc_new[15:8];
				res.frame_end = 1'b1;
			end
			default: res.frame_byte = data_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= dcf_pkg::R_DATA;
			frame_open_q <= 1'b0;
			crc_q <= dcf_pkg::CRC_INIT;
		end else begin
			if (take && at_last) begin
				frame_open_q <= !last_s1;
				crc_q <= last_s1 ? dcf_pkg::CRC_INIT : crc_new;
			end
			if (load) begin
				valid_s1 <= 1'b1;
				idx_q <= is_first ? dcf_pkg::R_HDR1 : dcf_pkg::R_DATA;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (take) begin
				idx_q <= dcf_pkg::res_idx_t'(idx_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_s1 <= is_first;
			last_s1 <= is_last;
			data_s1 <= payload_byte;
			cmd_s1 <= command_code;
			len_s1 <= count_clip + dcf_pkg::LEN_OFFSET;
			crc_cmd_s1 <= dcf_pkg::crc_feed(dcf_pkg::CRC_INIT, command_code);
		end
	end

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !done |=> valid_s1 && $stable(data_s1) && $stable(first_s1))
		else $error("input beat changed while its results were pending");

	a_crch_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && idx_q == dcf_pkg::R_CRCH |-> last_s1)
		else $error("CRC trailer emitted for a beat that does not end the frame");

	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && at_last && last_s1 |=> !frame_open_q && crc_q == dcf_pkg::CRC_INIT)
		else $error("frame state not cleared after the trailer");

	a_no_header_mid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !first_s1 |-> idx_q == dcf_pkg::R_DATA || idx_q == dcf_pkg::R_CRCL ||
			idx_q == dcf_pkg::R_CRCH)
		else $error("header result sequenced for a continuation beat");

endmodule

[rtl/dcf_out_reg.sv]
// Output register stage driving the master-side stream.
module dcf_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  dcf_pkg::result_t              res,
	output logic                          out_ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dcf_pkg::BYTE_W-1:0]    m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	logic                  valid_q;
	dcf_pkg::result_t      res_q;

	assign out_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = res_q.frame_byte;
	assign m_tlast = res_q.frame_end;
	assign m_tuser = res_q.run_end;

endmodule

[rtl/display_command_framer_crc16_top.sv]
// Top level of the display command framer with CRC-16/MODBUS trailer.
//
// Channel   Side     Beat contents
// s_*       in       tdata: command_code, payload_count, payload_byte; tuser: is_first; tlast: is_last
// m_*       out      tdata: frame_byte; tuser: run_end; tlast: frame_end
// APB       config   header_first at 0x0, header_second at 0x4
//
// A continuation beat yields one output beat and the block takes one such beat per cycle while
// m_tready stays high. A beat that opens a frame yields five output beats, a closing beat adds two,
// so one beat yields one to seven output beats, sent by the single output register one byte per
// cycle while m_tready is high. A beat that arrives with no frame open is dropped with no output.
// The first output beat goes through the input beat register and the output register; m_tready
// low stalls the sequencer and then s_tready. Reset clears the frame state and CRC to 0xFFFF.
module display_command_framer_crc16_top #(
	parameter int unsigned MAX_PAYLOAD = dcf_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [23:0]                          s_tdata,  // command_code, payload_count, payload_byte
	input  logic                                 s_tuser,  // is_first
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,  // frame_byte
	output logic                                 m_tuser,  // run_end
	output logic                                 m_tlast,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dcf_pkg::ADDR_W-1:0]           paddr,
	input  logic [dcf_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [dcf_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	dcf_pkg::headers_t     headers;
	dcf_pkg::result_t      res;
	logic                  res_valid;
	logic                  out_ready;

	dcf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.headers (headers)
	);

	dcf_emit #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.command_code  (s_tdata[7:0]),
		.payload_count (s_tdata[15:8]),
		.payload_byte  (s_tdata[23:16]),
		.is_first      (s_tuser),
		.is_last       (s_tlast),
		.headers       (headers),
		.out_ready     (out_ready),
		.res_valid     (res_valid),
		.res           (res)
	);

	dcf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
